### rtl/core/tlpte_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Two-level page table engine package
// Request and response types, opcodes, status codes and table geometry.
// -----------------------------------------------------------------------------
package tlpte_pkg;

   localparam int TABLE_POOL_DEFAULT = 64;
   localparam int DIRECTORY_ENTRIES  = 1024;
   localparam int PAGE_ENTRIES       = 1024;
   localparam int DIR_IDX_W          = 10;
   localparam int PAGE_IDX_W         = 10;
   localparam int TENT_W             = 23;

   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_UNMAP  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_OUT_OF_TABLES = 2'd1;
   localparam logic [1:0] ST_NOT_MAPPED    = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] virtual_address;
      logic [31:0] phys_address;
      logic [1:0]  page_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] translated_address;
      logic        mapped;
   } rsp_type;

endpackage

### rtl/core/tlpte_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// -----------------------------------------------------------------------------
module tlpte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

### rtl/core/two_level_page_table_engine_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Two-level page table engine
// Single page directory with a pool of second-level tables; map, unmap and
// translate requests run one at a time through a small sequencer.
// -----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one request (opcode, addresses, flags).
//   rsp_valid/rsp_stall/rsp_data return one response per request, in order.
//   A request is taken when valid is high and stall is low.
//   Sequence: the directory read is issued on acceptance and returns in
//   S_DIR; a map, a failed map, an op without present directory entry or
//   an unused opcode then goes to S_OUT, while unmap and lookup through a
//   present directory entry first do the dependent table read in S_TBL.
//   A new request is taken once the previous one has moved into the output
//   register, so requests run one at a time and never overlap.
//   Reset: a clearing pass writes zero to all TABLE_POOL*1024 table entries
//   (and the 1024 directory entries alongside); req_stall stays high until
//   it ends.
//   When rsp_stall is high the response holds in the output register; one
//   more request may finish behind it and then waits in the sequencer.
// -----------------------------------------------------------------------------
module two_level_page_table_engine_top #(
   parameter int TABLE_POOL = tlpte_pkg::TABLE_POOL_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlpte_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlpte_pkg::rsp_type rsp_data
);

   import tlpte_pkg::*;

   localparam int TIDX_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
   localparam int DENT_W    = TIDX_W + 3;
   localparam int TBL_DEPTH = TABLE_POOL * PAGE_ENTRIES;
   localparam int TA_W      = $clog2(TBL_DEPTH);
   localparam int NF_W      = $clog2(TABLE_POOL + 1);
   localparam logic [TA_W-1:0] CLR_LAST = TA_W'(TBL_DEPTH - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIR   = 3'd2;
   localparam logic [2:0] S_TBL   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [TA_W-1:0] clr_ff, clr_in;
   logic [NF_W-1:0] next_free_ff, next_free_in;
   logic [TA_W-1:0] slot_ff, slot_in;
   req_type         req_ff, req_in;
   rsp_type         res_ff, res_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic                 dir_we;
   logic [DIR_IDX_W-1:0] dir_addr;
   logic [DENT_W-1:0]    dir_wdata, dir_rdata;
   logic                 tbl_we;
   logic [TA_W-1:0]      tbl_addr;
   logic [TENT_W-1:0]    tbl_wdata, tbl_rdata;

   logic                   dir_present;
   logic                   pool_empty;
   logic [TIDX_W-1:0]      tidx_sel;
   logic [TIDX_W+PAGE_IDX_W-1:0] slot_full;
   logic [TA_W-1:0]        slot;
   logic [DENT_W-1:0]      new_dent;
   logic [TENT_W-1:0]      map_tent;

   tlpte_ram #(.WIDTH(DENT_W), .DEPTH(DIRECTORY_ENTRIES)) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .addr  (dir_addr),
      .wdata (dir_wdata),
      .rdata (dir_rdata)
   );

   tlpte_ram #(.WIDTH(TENT_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .addr  (tbl_addr),
      .wdata (tbl_wdata),
      .rdata (tbl_rdata)
   );

   assign dir_present = dir_rdata[0];
   assign pool_empty  = (next_free_ff == NF_W'(TABLE_POOL));
   assign tidx_sel    = dir_present ? dir_rdata[DENT_W-1:3] : next_free_ff[TIDX_W-1:0];
   assign slot_full   = {tidx_sel, req_ff.virtual_address[21:12]};
   assign slot        = slot_full[TA_W-1:0];
   assign new_dent    = {next_free_ff[TIDX_W-1:0], req_ff.page_flags, 1'b1};
   assign map_tent    = {req_ff.phys_address[31:12], req_ff.page_flags, 1'b1};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      next_free_in = next_free_ff;
      slot_in      = slot_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dir_we       = 1'b0;
      dir_addr     = req_ff.virtual_address[31:22];
      dir_wdata    = new_dent;
      tbl_we       = 1'b0;
      tbl_addr     = slot;
      tbl_wdata    = map_tent;
      unique case (state_ff)
         S_CLEAR: begin
            dir_we    = 1'b1;
            dir_addr  = clr_ff[DIR_IDX_W-1:0];
            dir_wdata = '0;
            tbl_we    = 1'b1;
            tbl_addr  = clr_ff;
            tbl_wdata = '0;
            clr_in    = clr_ff + TA_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            dir_addr = req_data.virtual_address[31:22];
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            res_in.status             = ST_OK;
            res_in.translated_address = '0;
            res_in.mapped             = 1'b0;
            slot_in                   = slot;
            state_in                  = S_OUT;
            unique case (req_ff.opcode)
               OP_MAP: begin
                  if (!dir_present && pool_empty) begin
                     res_in.status = ST_OUT_OF_TABLES;
                  end else begin
                     tbl_we = 1'b1;
                     if (!dir_present) begin
                        dir_we       = 1'b1;
                        next_free_in = next_free_ff + NF_W'(1);
                     end
                  end
               end
               OP_UNMAP: begin
                  if (dir_present) begin
                     state_in = S_TBL;
                  end
               end
               OP_LOOKUP: begin
                  if (dir_present) begin
                     state_in = S_TBL;
                  end else begin
                     res_in.status = ST_NOT_MAPPED;
                  end
               end
               default: ;
            endcase
         end
         S_TBL: begin
            tbl_addr = slot_ff;
            state_in = S_OUT;
            if (req_ff.opcode == OP_UNMAP) begin
               tbl_we    = 1'b1;
               tbl_wdata = {tbl_rdata[TENT_W-1:1], 1'b0};
            end else if (tbl_rdata[0]) begin
               res_in.translated_address = {tbl_rdata[TENT_W-1:3],
                                            req_ff.virtual_address[11:0]};
               res_in.mapped             = 1'b1;
            end else begin
               res_in.status = ST_NOT_MAPPED;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff <= slot_in;
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(TABLE_POOL))
      else $error("table pool count beyond pool size");

   a_accept_to_dir: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DIR))
      else $error("accepted request did not start directory read");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside output state");

   a_mapped_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mapped) |-> (rsp_data.status == ST_OK))
      else $error("mapped response with error status");

   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (req_stall && !rsp_valid))
      else $error("activity during clearing pass");
`endif

endmodule
